[rtl/core/bdme_pkg.sv]
// ----------------------------------------------------------------------------
// bdme_pkg - shared types and constants
// Register codes, configuration bundle, state encodings and saturation limits
// for the birth-death master equation right-hand-side block.
// ----------------------------------------------------------------------------
package bdme_pkg;

  localparam int unsigned MAX_LEN_DEF   = 64;
  localparam int unsigned MAX_EXTRA_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned XW     = 33;  // probability, Q1.32
  localparam int unsigned WSW    = 48;  // weighted sum, Q16.32
  localparam int unsigned OUTW   = 64;  // result, Q32.32
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [OUTW-1:0] POS_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OUTW-1:0] NEG_SAT = 64'h8000_0000_0000_0000;

  typedef enum logic [CFG_AW-1:0] {
    REG_BIRTH_RATE  = 3'd0,
    REG_DEATH_RATE  = 3'd1,
    REG_CARRY_CAP   = 3'd2,
    REG_ACTIVE_LEN  = 3'd3,
    REG_EXTRA_COUNT = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] BIRTH_RATE_RST  = 32'd16777216;
  localparam logic [31:0] DEATH_RATE_RST  = 32'd0;
  localparam logic [31:0] CARRY_CAP_RST   = 32'd6553600;
  localparam logic [6:0]  ACTIVE_LEN_RST  = 7'd64;
  localparam logic [4:0]  EXTRA_COUNT_RST = 5'd1;
  localparam logic [31:0] CARRY_CAP_MIN   = 32'd65536;

  typedef struct packed {
    logic [31:0] birth_rate;
    logic [31:0] death_rate;
    logic [31:0] carrying_capacity;
    logic [6:0]  active_length;
    logic [4:0]  extra_count;
  } cfg_t;

  typedef enum logic [1:0] {
    SL_LOAD,
    SL_RUN,
    SL_DONE
  } slope_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NEXT,
    BK_LAM_A,
    BK_LAM_B,
    BK_TLOAD,
    BK_TMUL,
    BK_TACC,
    BK_DOUT,
    BK_RINIT,
    BK_RDIV,
    BK_RFIN,
    BK_ROUT
  } back_state_e;

endpackage

[rtl/core/bdme_queue.sv]
// ----------------------------------------------------------------------------
// bdme_queue - short register queue
// Holds classified beats between the front and the back end.
// ----------------------------------------------------------------------------
module bdme_queue
  import bdme_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[rtl/core/bdme_front.sv]
// ----------------------------------------------------------------------------
// bdme_front - input side
// Accepts probability beats, tracks position and weighted sum, marks the end
// of a pass and recomputes the birth-rate slope after every register write.
// ----------------------------------------------------------------------------
module bdme_front
  import bdme_pkg::*;
#(
  parameter int unsigned MAX_LEN   = MAX_LEN_DEF,
  parameter int unsigned MAX_EXTRA = MAX_EXTRA_DEF,
  parameter int unsigned IDXW      = $clog2(MAX_LEN),
  parameter int unsigned EXW       = $clog2(MAX_EXTRA + 2),
  parameter int unsigned EW        = 1 + EXW + IDXW + WSW + 3 * XW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  cfg_we_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [XW-1:0]  in_x_i,
  output logic                  push_o,
  output logic [EW-1:0]         push_data_o,
  input  logic                  full_i,
  output logic signed [WSW-1:0] slope_o
);

  localparam int unsigned LENW = $clog2(MAX_LEN + 1);
  localparam int unsigned PRW  = IDXW + 1 + XW;
  localparam logic signed [WSW+1:0] WS_MAX = (WSW+2)'({1'b0, {(WSW-1){1'b1}}});
  localparam logic signed [WSW+1:0] WS_MIN = -WS_MAX - (WSW+2)'(1);

  typedef struct packed {
    logic                  last;
    logic [EXW-1:0]        extra;
    logic [IDXW-1:0]       idx;
    logic signed [WSW-1:0] ws;
    logic signed [XW-1:0]  older;
    logic signed [XW-1:0]  newer;
    logic signed [XW-1:0]  x;
  } entry_t;

  logic [IDXW-1:0]       idx_q;
  logic signed [XW-1:0]  older_q, newer_q;
  logic signed [WSW-1:0] ws_q;
  logic [LENW-1:0]       len_c;
  logic [EXW-1:0]        extra_c;
  logic                  is_last, accept, slope_ready;
  logic signed [PRW-1:0] tx_prod;
  logic signed [WSW+1:0] ws_sum;
  logic signed [WSW-1:0] ws_sat;
  entry_t                entry;

  always_comb begin
    if (32'(cfg_i.active_length) > 32'(MAX_LEN)) begin
      len_c = LENW'(MAX_LEN);
    end else if (cfg_i.active_length < 7'd2) begin
      len_c = LENW'(2);
    end else begin
      len_c = LENW'(cfg_i.active_length);
    end
    if (32'(cfg_i.extra_count) > 32'(MAX_EXTRA)) begin
      extra_c = EXW'(MAX_EXTRA);
    end else begin
      extra_c = EXW'(cfg_i.extra_count);
    end
  end

  assign is_last = ((LENW+1)'(idx_q) + (LENW+1)'(1)) >= (LENW+1)'(len_c);

  // index times probability, then saturate the running sum
  assign tx_prod = $signed({1'b0, idx_q}) * in_x_i;
  assign ws_sum  = (WSW+2)'(ws_q) + (WSW+2)'(tx_prod);

  always_comb begin
    if (ws_sum > WS_MAX) begin
      ws_sat = WSW'(WS_MAX);
    end else if (ws_sum < WS_MIN) begin
      ws_sat = WSW'(WS_MIN);
    end else begin
      ws_sat = WSW'(ws_sum);
    end
  end

  assign in_ready_o = slope_ready && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    entry.last  = is_last;
    entry.extra = extra_c;
    entry.idx   = idx_q;
    entry.ws    = ws_sat;
    entry.older = older_q;
    entry.newer = newer_q;
    entry.x     = in_x_i;
  end

  assign push_o      = accept;
  assign push_data_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      older_q <= '0;
      newer_q <= '0;
      ws_q    <= '0;
    end else if (accept) begin
      if (is_last) begin
        idx_q   <= '0;
        older_q <= '0;
        newer_q <= '0;
        ws_q    <= '0;
      end else begin
        idx_q   <= idx_q + IDXW'(1);
        older_q <= newer_q;
        newer_q <= in_x_i;
        ws_q    <= ws_sat;
      end
    end
  end

  // slope = (la - mu) * 2^24 / K, magnitude truncated, restoring division
  slope_state_e     sl_state_q, sl_state_d;
  logic [55:0]      dvd_q;
  logic [31:0]      rem_q;
  logic [47:0]      quo_q;
  logic [5:0]       scnt_q;
  logic             sneg_q;
  logic signed [WSW-1:0] slope_q;
  logic signed [32:0] diff;
  logic [31:0]      diff_mag, k_eff;
  logic [32:0]      rem_n;
  logic             rem_ge;

  assign diff     = $signed({1'b0, cfg_i.birth_rate}) - $signed({1'b0, cfg_i.death_rate});
  assign diff_mag = diff[32] ? 32'(-diff) : 32'(diff);
  assign k_eff    = (cfg_i.carrying_capacity < CARRY_CAP_MIN) ? CARRY_CAP_MIN
                                                              : cfg_i.carrying_capacity;
  assign rem_n    = {rem_q, dvd_q[55]};
  assign rem_ge   = rem_n >= {1'b0, k_eff};
  assign slope_ready = (sl_state_q == SL_DONE);
  assign slope_o     = slope_q;

  always_comb begin
    sl_state_d = sl_state_q;
    unique case (sl_state_q)
      SL_LOAD: sl_state_d = SL_RUN;
      SL_RUN:  if (scnt_q == 6'd55) sl_state_d = SL_DONE;
      SL_DONE: sl_state_d = SL_DONE;
      default: sl_state_d = SL_LOAD;
    endcase
    if (cfg_we_i) begin
      sl_state_d = SL_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_state_q <= SL_LOAD;
    end else begin
      sl_state_q <= sl_state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (sl_state_q)
      SL_LOAD: begin
        dvd_q  <= {diff_mag, 24'b0};
        rem_q  <= '0;
        quo_q  <= '0;
        scnt_q <= '0;
        sneg_q <= diff[32];
      end
      SL_RUN: begin
        dvd_q  <= {dvd_q[54:0], 1'b0};
        rem_q  <= rem_ge ? 32'(rem_n - {1'b0, k_eff}) : 32'(rem_n);
        quo_q  <= {quo_q[46:0], rem_ge};
        scnt_q <= scnt_q + 6'd1;
        if (scnt_q == 6'd55) begin
          slope_q <= sneg_q ? -$signed({quo_q[46:0], rem_ge})
                            : $signed({quo_q[46:0], rem_ge});
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/bdme_back.sv]
// ----------------------------------------------------------------------------
// bdme_back - arithmetic side
// Works through queued beats: three-point stencil derivatives on a shared
// radix-16 serial multiplier, and the trailing mu over weighted-sum terms.
// ----------------------------------------------------------------------------
module bdme_back
  import bdme_pkg::*;
#(
  parameter int unsigned MAX_LEN   = MAX_LEN_DEF,
  parameter int unsigned MAX_EXTRA = MAX_EXTRA_DEF,
  parameter int unsigned IDXW      = $clog2(MAX_LEN),
  parameter int unsigned EXW       = $clog2(MAX_EXTRA + 2),
  parameter int unsigned EW        = 1 + EXW + IDXW + WSW + 3 * XW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic signed [WSW-1:0] slope_i,
  input  logic                  q_valid_i,
  input  logic [EW-1:0]         q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUTW-1:0]       out_data_o,
  output logic                  out_rate_o,
  output logic                  out_dz_o,
  output logic                  out_last_o
);

  localparam int unsigned FW   = IDXW + 2;
  localparam int unsigned SW   = XW + FW;
  localparam int unsigned ND   = (SW + 3) / 4;
  localparam int unsigned MAGW = ND * 4;
  localparam int unsigned DCW  = $clog2(ND + 1);

  typedef struct packed {
    logic                  last;
    logic [EXW-1:0]        extra;
    logic [IDXW-1:0]       idx;
    logic signed [WSW-1:0] ws;
    logic signed [XW-1:0]  older;
    logic signed [XW-1:0]  newer;
    logic signed [XW-1:0]  x;
  } entry_t;

  back_state_e state_q, state_d;

  entry_t                entry_q;
  logic                  pend_a_q, pend_b_q, pend_r_q;
  logic [IDXW-1:0]       job_k_q;
  logic signed [XW-1:0]  job_xm_q, job_x0_q, job_xp_q;
  logic                  job_last_q;
  logic [63:0]           lam_k_q, coef3_q, coef_q;
  logic [1:0]            tsel_q;
  logic [MAGW-1:0]       mag_q;
  logic                  neg_q;
  logic [127:0]          prod_q, acc_q;
  logic [DCW-1:0]        dcnt_q;
  logic [WSW-1:0]        rem_q, div_d_q;
  logic [71:0]           dvd_q;
  logic [63:0]           quo_q;
  logic                  over_q;
  logic [6:0]            rcnt_q;
  logic [63:0]           rate_val_q;
  logic                  rate_dz_q;
  logic [EXW-1:0]        left_q;
  logic                  out_valid_q, out_rate_q, out_dz_q, out_last_q;
  logic [OUTW-1:0]       out_data_q;

  logic                  out_free;
  logic signed [FW-1:0]  kx, fac_l, fac_t;
  logic signed [FW+WSW-1:0] sl_prod;
  logic signed [63:0]    lam_raw;
  logic [63:0]           lam_v, mu64, coef_t;
  logic signed [XW-1:0]  x_t;
  logic signed [SW-1:0]  s_t, s_neg;
  logic [67:0]           pp;
  logic [95:0]           shifted;
  logic [OUTW-1:0]       deriv_sat;
  logic [WSW:0]          rrem_n;
  logic                  rge;
  logic [WSW-1:0]        ws_abs;
  logic [63:0]           rate_fin;

  entry_t q_entry;
  assign q_entry = q_data_i;

  assign out_free = !out_valid_q || out_ready_i;
  assign mu64     = {24'b0, cfg_i.death_rate, 8'b0};
  assign kx       = $signed({2'b00, job_k_q});

  // birth rate at the current index: max(0, la - slope*(j-1))
  assign fac_l   = (state_q == BK_LAM_A) ? kx - FW'(1) : kx;
  assign sl_prod = slope_i * fac_l;
  assign lam_raw = $signed({24'b0, cfg_i.birth_rate, 8'b0}) - 64'(sl_prod);
  assign lam_v   = lam_raw[63] ? 64'd0 : lam_raw;

  always_comb begin
    case (tsel_q)
      2'd0: begin
        fac_t  = kx - FW'(1);
        x_t    = job_xm_q;
        coef_t = lam_k_q;
      end
      2'd1: begin
        fac_t  = kx + FW'(1);
        x_t    = job_xp_q;
        coef_t = mu64;
      end
      default: begin
        fac_t  = kx;
        x_t    = job_x0_q;
        coef_t = coef3_q;
      end
    endcase
  end

  assign s_t   = fac_t * x_t;
  assign s_neg = -s_t;
  assign pp    = 68'(coef_q) * 68'(mag_q[MAGW-1 -: 4]);

  // drop 32 fraction bits, saturate to 64
  assign shifted   = acc_q[127:32];
  assign deriv_sat = ((&shifted[95:63]) || !(|shifted[95:63])) ? shifted[63:0]
                   : (acc_q[127] ? NEG_SAT : POS_SAT);

  assign ws_abs = entry_q.ws[WSW-1] ? WSW'(-entry_q.ws) : WSW'(entry_q.ws);
  assign rrem_n = {rem_q, dvd_q[71]};
  assign rge    = rrem_n >= {1'b0, div_d_q};

  always_comb begin
    if (!entry_q.ws[WSW-1]) begin
      rate_fin = (over_q || quo_q > POS_SAT) ? POS_SAT : quo_q;
    end else begin
      rate_fin = (over_q || quo_q > NEG_SAT) ? NEG_SAT : 64'(-quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = BK_NEXT;
        end
      end
      BK_NEXT: begin
        if (pend_a_q || pend_b_q) begin
          state_d = BK_LAM_A;
        end else if (pend_r_q) begin
          state_d = BK_RINIT;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_LAM_A: state_d = BK_LAM_B;
      BK_LAM_B: state_d = BK_TLOAD;
      BK_TLOAD: state_d = BK_TMUL;
      BK_TMUL:  if (dcnt_q == DCW'(ND - 1)) state_d = BK_TACC;
      BK_TACC:  state_d = (tsel_q == 2'd2) ? BK_DOUT : BK_TLOAD;
      BK_DOUT:  if (out_free) state_d = BK_NEXT;
      BK_RINIT: state_d = (entry_q.ws == '0) ? BK_ROUT : BK_RDIV;
      BK_RDIV:  if (rcnt_q == 7'd71) state_d = BK_RFIN;
      BK_RFIN:  state_d = BK_ROUT;
      BK_ROUT:  if (out_free && left_q == EXW'(1)) state_d = BK_NEXT;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
      pend_r_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // load a new result beat, else drop the one just taken
      if ((state_q == BK_DOUT || state_q == BK_ROUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            pend_a_q <= (q_entry.idx != '0);
            pend_b_q <= q_entry.last;
            pend_r_q <= q_entry.last && (q_entry.extra != '0);
          end
        end
        BK_NEXT: begin
          if (pend_a_q) begin
            pend_a_q <= 1'b0;
          end else if (pend_b_q) begin
            pend_b_q <= 1'b0;
          end else begin
            pend_r_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) entry_q <= q_entry;
      end
      BK_NEXT: begin
        if (pend_a_q) begin
          job_k_q    <= entry_q.idx - IDXW'(1);
          job_xm_q   <= entry_q.older;
          job_x0_q   <= entry_q.newer;
          job_xp_q   <= entry_q.x;
          job_last_q <= 1'b0;
        end else if (pend_b_q) begin
          job_k_q    <= entry_q.idx;
          job_xm_q   <= entry_q.newer;
          job_x0_q   <= entry_q.x;
          job_xp_q   <= '0;
          job_last_q <= (entry_q.extra == '0);
        end
      end
      BK_LAM_A: begin
        lam_k_q <= lam_v;
        acc_q   <= '0;
        tsel_q  <= 2'd0;
      end
      BK_LAM_B: coef3_q <= lam_v + mu64;
      BK_TLOAD: begin
        coef_q <= coef_t;
        mag_q  <= MAGW'($unsigned(s_t[SW-1] ? s_neg : s_t));
        neg_q  <= s_t[SW-1] ^ (tsel_q == 2'd2);
        prod_q <= '0;
        dcnt_q <= '0;
      end
      BK_TMUL: begin
        prod_q <= (prod_q << 4) + 128'(pp);
        mag_q  <= mag_q << 4;
        dcnt_q <= dcnt_q + DCW'(1);
      end
      BK_TACC: begin
        acc_q  <= neg_q ? acc_q - prod_q : acc_q + prod_q;
        tsel_q <= tsel_q + 2'd1;
      end
      BK_DOUT: begin
        if (out_free) begin
          out_data_q <= deriv_sat;
          out_rate_q <= 1'b0;
          out_dz_q   <= 1'b0;
          out_last_q <= job_last_q;
        end
      end
      BK_RINIT: begin
        rate_val_q <= POS_SAT;
        rate_dz_q  <= (entry_q.ws == '0);
        left_q     <= entry_q.extra;
        div_d_q    <= ws_abs;
        rem_q      <= '0;
        quo_q      <= '0;
        over_q     <= 1'b0;
        rcnt_q     <= '0;
        dvd_q      <= {cfg_i.death_rate, 40'b0};
      end
      BK_RDIV: begin
        rem_q  <= rge ? WSW'(rrem_n - {1'b0, div_d_q}) : WSW'(rrem_n);
        quo_q  <= {quo_q[62:0], rge};
        over_q <= over_q | quo_q[63];
        dvd_q  <= {dvd_q[70:0], 1'b0};
        rcnt_q <= rcnt_q + 7'd1;
      end
      BK_RFIN: rate_val_q <= rate_fin;
      BK_ROUT: begin
        if (out_free) begin
          out_data_q <= rate_val_q;
          out_rate_q <= 1'b1;
          out_dz_q   <= rate_dz_q;
          out_last_q <= (left_q == EXW'(1));
          left_q     <= left_q - EXW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_rate_o  = out_rate_q;
  assign out_dz_o    = out_dz_q;
  assign out_last_o  = out_last_q;

endmodule

[rtl/core/birth_death_master_eq_rhs.sv]
// Derivatives come from one shared serial multiplier, and the back end works on one beat at a
//   time, while the queue lets the front end take further beats. The last beat of a pass
//   adds a second derivative and, if extra_count is nonzero, a restoring division for mu/S,
//   then one rate term per cycle while the output is not stalled.
// Reset and every register write start a slope division; s_axis_tready stays low meanwhile.
// Reset is asynchronous, active low, clears the control state and loads the register defaults.
// ----------------------------------------------------------------------------
// birth_death_master_eq_rhs - master equation right-hand side, streamed
// Front end classifies probability beats and keeps the running sums, a short
// queue decouples it from the back end that forms derivatives and rate terms.
// ----------------------------------------------------------------------------
module birth_death_master_eq_rhs
  import bdme_pkg::*;
#(
  parameter int unsigned MAX_LEN   = MAX_LEN_DEF,
  parameter int unsigned MAX_EXTRA = MAX_EXTRA_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  // probability beats
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,   // [32:0] prob_value
  // result beats
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // [63:0] deriv_value
  output logic [1:0]        m_axis_tuser,   // [0] is_rate_term, [1] divide_by_zero
  output logic              m_axis_tlast    // last_of_pass
);

  localparam int unsigned IDXW = $clog2(MAX_LEN);
  localparam int unsigned EXW  = $clog2(MAX_EXTRA + 2);
  localparam int unsigned EW   = 1 + EXW + IDXW + WSW + 3 * XW;

  cfg_t cfg_q;

  // register file; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.birth_rate        <= BIRTH_RATE_RST;
      cfg_q.death_rate        <= DEATH_RATE_RST;
      cfg_q.carrying_capacity <= CARRY_CAP_RST;
      cfg_q.active_length     <= ACTIVE_LEN_RST;
      cfg_q.extra_count       <= EXTRA_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BIRTH_RATE:  cfg_q.birth_rate        <= cfg_wdata_i;
        REG_DEATH_RATE:  cfg_q.death_rate        <= cfg_wdata_i;
        REG_CARRY_CAP:   cfg_q.carrying_capacity <= cfg_wdata_i;
        REG_ACTIVE_LEN:  cfg_q.active_length     <= cfg_wdata_i[6:0];
        REG_EXTRA_COUNT: cfg_q.extra_count       <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  logic                  push, full, q_valid, pop;
  logic [EW-1:0]         push_data, q_data;
  logic signed [WSW-1:0] slope;

  // accept beats, keep neighbours and weighted sum, derive the slope
  bdme_front #(
    .MAX_LEN  (MAX_LEN),
    .MAX_EXTRA(MAX_EXTRA),
    .IDXW     (IDXW),
    .EXW      (EXW),
    .EW       (EW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_x_i     ($signed(s_axis_tdata[32:0])),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full),
    .slope_o    (slope)
  );

  // hold classified beats so either side may stall
  bdme_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  // form derivatives and rate terms, output register inside
  bdme_back #(
    .MAX_LEN  (MAX_LEN),
    .MAX_EXTRA(MAX_EXTRA),
    .IDXW     (IDXW),
    .EXW      (EXW),
    .EW       (EW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .slope_i    (slope),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_rate_o (m_axis_tuser[0]),
    .out_dz_o   (m_axis_tuser[1]),
    .out_last_o (m_axis_tlast)
  );

endmodule

[rtl/core/bdme_checker.sv]
// ----------------------------------------------------------------------------
// bdme_checker - port-level checks
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module bdme_checker
  import bdme_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [63:0]       m_axis_tdata,
  input logic [1:0]        m_axis_tuser,
  input logic              m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // zero divisor only on a rate term
  a_dz_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("divide_by_zero on a derivative");

  // zero divisor gives the positive limit
  a_dz_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == POS_SAT)
    else $error("divide_by_zero without saturation");

  // a register write restarts the slope and blocks input
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input ready right after a register write");

endmodule

bind birth_death_master_eq_rhs bdme_checker u_checker (.*);
